// ===== rtl/kmd_pkg.sv =====
package kmd_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned RowW = 3;
  localparam int unsigned ColW = 8;
  localparam int unsigned ColIdxW = 3;

  // Matrix size defaults
  localparam int unsigned ROWS_DEFAULT = 8;
  localparam int unsigned COLS_DEFAULT = 8;

  // Pending change word handed from the row store to the event emitter
  typedef struct packed {
    logic [RowW-1:0] row;
    logic [ColW-1:0] mask;
    logic [ColW-1:0] sample;
  } pend_t;

  // Handshake between row store and emitter
  typedef struct packed {
    logic load;
    pend_t word;
  } pend_load_t;

endpackage

// ===== rtl/kmd_in_if.sv =====
interface kmd_in_if;
  logic valid;
  logic ready;
  logic [kmd_pkg::RowW-1:0] scan_row;
  logic [kmd_pkg::ColW-1:0] column_bits;

  modport source (output valid, output scan_row, output column_bits, input ready);
  modport sink (input valid, input scan_row, input column_bits, output ready);
endinterface

// ===== rtl/kmd_out_if.sv =====
interface kmd_out_if;
  logic valid;
  logic ready;
  logic [kmd_pkg::ColIdxW-1:0] event_column;
  logic [kmd_pkg::RowW-1:0] event_row;
  logic pressed;
  logic last_event;

  modport source (output valid, output event_column, output event_row, output pressed,
                  output last_event, input ready);
  modport sink (input valid, input event_column, input event_row, input pressed,
                input last_event, output ready);
endinterface

// ===== rtl/key_matrix_debounce_scanner.sv =====
// Channel   Dir  Payload                                        Accepted when
// scan_in   in   scan_row[2:0], column_bits[7:0]                valid && ready
// events    out  event_column[2:0], event_row[2:0], pressed,    valid && ready
//                last_event
//
// A sample word is compared and the row state updated in the cycle it is
// accepted; a changed row is queued as one pending word and the emitter sends
// one event per cycle from it while the events port is not stalled; each event
// passes through the pending word register and then the output register. A
// changed sample holds off the next sample until the event of its last changed
// column is being sent. Reset clears both row stores at once. A stalled events
// port holds its word and stops new samples once the pending word is full.
module key_matrix_debounce_scanner #(
  parameter int unsigned ROWS = kmd_pkg::ROWS_DEFAULT,
  parameter int unsigned COLS = kmd_pkg::COLS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  kmd_in_if.sink    scan_in,
  kmd_out_if.source events
);

  kmd_pkg::pend_load_t pend;
  logic                can_load;

  kmd_row_store #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .scan_in (scan_in),
    .can_load(can_load),
    .pend_out(pend)
  );

  kmd_event_emitter u_emit (
    .clk     (clk),
    .rst     (rst),
    .pend_in (pend),
    .can_load(can_load),
    .events  (events)
  );

endmodule

// ===== rtl/kmd_row_store.sv =====
module kmd_row_store #(
  parameter int unsigned ROWS = kmd_pkg::ROWS_DEFAULT,
  parameter int unsigned COLS = kmd_pkg::COLS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  kmd_in_if.sink              scan_in,
  input  logic                can_load,
  output kmd_pkg::pend_load_t pend_out
);

  localparam int unsigned RowIdxW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [kmd_pkg::ColW-1:0] ColMask =
    kmd_pkg::ColW'((9'd1 << COLS) - 9'd1);

  logic [kmd_pkg::ColW-1:0] last_sample [ROWS];
  logic [kmd_pkg::ColW-1:0] stable_state [ROWS];

  logic                     accept;
  logic                     in_range;
  logic [RowIdxW-1:0]       idx;
  logic [kmd_pkg::ColW-1:0] sample;
  logic [kmd_pkg::ColW-1:0] last_rd;
  logic [kmd_pkg::ColW-1:0] stable_rd;
  logic                     is_new;
  logic                     is_change;

  assign scan_in.ready = can_load;
  assign accept = scan_in.valid && can_load;

  // Row lookup and compare
  assign in_range  = ({1'b0, scan_in.scan_row} < (kmd_pkg::RowW + 1)'(ROWS));
  assign idx       = RowIdxW'(scan_in.scan_row);
  assign sample    = scan_in.column_bits & ColMask;
  assign last_rd   = last_sample[idx];
  assign stable_rd = stable_state[idx];
  assign is_new    = (sample != last_rd);
  assign is_change = !is_new && (sample != stable_rd);

  // Change word for the emitter
  always_comb begin
    pend_out.load        = accept && in_range && is_change;
    pend_out.word.row    = scan_in.scan_row;
    pend_out.word.mask   = sample ^ stable_rd;
    pend_out.word.sample = sample;
  end

  // Per-row state update on each accepted in-range word
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        last_sample[r]  <= '0;
        stable_state[r] <= '0;
      end
    end else if (accept && in_range) begin
      if (is_new) begin
        last_sample[idx] <= sample;
      end else if (is_change) begin
        stable_state[idx] <= sample;
      end
    end
  end

endmodule

// ===== rtl/kmd_event_emitter.sv =====
module kmd_event_emitter (
  input  logic                clk,
  input  logic                rst,
  input  kmd_pkg::pend_load_t pend_in,
  output logic                can_load,
  kmd_out_if.source           events
);

  logic [kmd_pkg::RowW-1:0]    pend_row;
  logic [kmd_pkg::ColW-1:0]    pend_mask;
  logic [kmd_pkg::ColW-1:0]    pend_sample;
  logic                        out_valid;
  logic [kmd_pkg::ColIdxW-1:0] out_col;
  logic [kmd_pkg::RowW-1:0]    out_row;
  logic                        out_pressed;
  logic                        out_last;

  logic                        advance;
  logic [kmd_pkg::ColIdxW-1:0] low_col;
  logic [kmd_pkg::ColW-1:0]    rest;

  // Lowest pending column
  always_comb begin
    low_col = '0;
    for (int c = kmd_pkg::ColW - 1; c >= 0; c--) begin
      if (pend_mask[c]) begin
        low_col = kmd_pkg::ColIdxW'(c);
      end
    end
  end

  assign rest     = pend_mask & (pend_mask - kmd_pkg::ColW'(1));
  assign advance  = (pend_mask != '0) && (!out_valid || events.ready);
  assign can_load = (pend_mask == '0) || (advance && (rest == '0));

  // Pending change word
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_mask <= '0;
    end else if (pend_in.load) begin
      pend_mask <= pend_in.word.mask;
    end else if (advance) begin
      pend_mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_in.load) begin
      pend_row    <= pend_in.word.row;
      pend_sample <= pend_in.word.sample;
    end
  end

  // Output register, one event word per cycle while the events port is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (events.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_col     <= low_col;
      out_row     <= pend_row;
      out_pressed <= pend_sample[low_col];
      out_last    <= (rest == '0);
    end
  end

  assign events.valid        = out_valid;
  assign events.event_column = out_col;
  assign events.event_row    = out_row;
  assign events.pressed      = out_pressed;
  assign events.last_event   = out_last;

endmodule
